FILE: rtl/plc_pkg.sv
`default_nettype none

package plc_pkg;

  // Program shape and channel counts.
  localparam int MAX_ELEMENTS    = 8;
  localparam int INPUT_CHANNELS  = 8;
  localparam int OUTPUT_CHANNELS = 8;

  // Element register slots, index and field widths.
  localparam int SLOTS     = 8;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int CFG_IDX_W = 4;
  localparam int ELEM_W    = 15;
  localparam int CHAN_W    = 4;
  localparam int BITS_W    = 8;

  // Only channels that exist both by count and by vector width are usable.
  localparam int IN_LIMIT  = (INPUT_CHANNELS  < BITS_W) ? INPUT_CHANNELS  : BITS_W;
  localparam int OUT_LIMIT = (OUTPUT_CHANNELS < BITS_W) ? OUTPUT_CHANNELS : BITS_W;

  typedef enum logic [1:0] {
    OP_AND = 2'd0,
    OP_OR  = 2'd1,
    OP_NOT = 2'd2,
    OP_RS  = 2'd3
  } op_t;

  typedef struct packed {
    logic              valid;
    op_t               op;
    logic [CHAN_W-1:0] chan_a;
    logic [CHAN_W-1:0] chan_b;
    logic [CHAN_W-1:0] out_chan;
  } elem_t;

  // Level of a numbered input channel; unused channel numbers read low.
  function automatic logic read_chan(input logic [BITS_W-1:0] bits,
                                     input logic [CHAN_W-1:0] ch);
    logic [CHAN_W-1:0] idx;
    idx = ch - CHAN_W'(1);
    if ((ch == '0) || (ch > CHAN_W'(IN_LIMIT))) begin
      return 1'b0;
    end
    return bits[idx[$clog2(BITS_W)-1:0]];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/plc_logic_scan.sv
`default_nettype none

// Scans a small relay program of up to eight elements once per item.
// Input channel: in_valid / in_stall carry in_input_bits, the levels of
// input channels 1..8. Result channel: out_valid / out_stall carry
// out_output_bits, the output channel levels after the scan.
// Configuration: cfg_valid / cfg_ready write cfg_data into element
// register cfg_index; indexes above 7 are ignored. cfg_ready is always
// high. Writing an element clears its latch state.
// Each item passes one input register, then the eight-element chain of
// gates feeding the result register. The block takes one item per cycle
// while the receiver does not stall; that chain is the only logic path.
// When the receiver stalls, the result register holds and one more item
// is taken into the input register; after that in_stall rises.
// Synchronous reset clears the pipeline, the output latch, all latch
// states and all element registers.

module plc_logic_scan
  import plc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [BITS_W-1:0]    in_input_bits,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic      [BITS_W-1:0]    out_output_bits,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ELEM_W-1:0]    cfg_data
);

  elem_t             elem_r [SLOTS];
  logic [SLOTS-1:0]  latch_state_r;
  logic [BITS_W-1:0] output_latch_r;
  logic              s1_valid_r;
  logic [BITS_W-1:0] s1_bits_r;
  logic              out_valid_r;
  logic [BITS_W-1:0] out_bits_r;

  logic              out_free;
  logic              advance;
  logic              take_in;
  logic              cfg_hit;
  logic [BITS_W-1:0] chain [SLOTS+1];
  logic [SLOTS-1:0]  latch_nxt;
  logic [SLOTS-1:0]  latch_state_nxt;

  // Handshake control.
  assign out_free  = ~out_valid_r | ~out_stall;
  assign advance   = s1_valid_r & out_free;
  assign in_stall  = s1_valid_r & ~out_free;
  assign take_in   = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid & cfg_ready & (cfg_index < CFG_IDX_W'(SLOTS));

  assign out_valid       = out_valid_r;
  assign out_output_bits = out_bits_r;

  // Element chain, evaluated in list order.
  assign chain[0] = output_latch_r;
  for (genvar i = 0; i < SLOTS; i++) begin : g_elem
    plc_elem u_elem (
      .enable_i (1'(i < MAX_ELEMENTS)),
      .elem_i   (elem_r[i]),
      .bits_i   (s1_bits_r),
      .latch_i  (latch_state_r[i]),
      .outs_i   (chain[i]),
      .latch_o  (latch_nxt[i]),
      .outs_o   (chain[i+1])
    );
  end

  // Latch states follow each scan and clear when their element is written.
  always_comb begin
    latch_state_nxt = advance ? latch_nxt : latch_state_r;
    if (cfg_hit) begin
      latch_state_nxt[cfg_index[SLOT_W-1:0]] = 1'b0;
    end
  end

  // Pipeline registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take_in) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (take_in) begin
      s1_bits_r <= in_input_bits;
    end
    if (advance) begin
      out_bits_r <= chain[SLOTS];
    end
  end

  // Program and scan state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      output_latch_r <= '0;
      latch_state_r  <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        elem_r[i] <= '0;
      end
    end else begin
      latch_state_r <= latch_state_nxt;
      if (advance) begin
        output_latch_r <= chain[SLOTS];
      end
      if (cfg_hit) begin
        elem_r[cfg_index[SLOT_W-1:0]] <= elem_t'(cfg_data);
      end
    end
  end

  // The result on offer always matches the stored output latch.
  a_result_matches_latch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_output_bits == output_latch_r))
    else $error("result differs from output latch");

  // An item waiting behind a stalled result is kept.
  a_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && out_stall) |=> s1_valid_r)
    else $error("pending item lost under stall");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !s1_valid_r))
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

FILE: rtl/plc_elem.sv
`default_nettype none

module plc_elem
  import plc_pkg::*;
(
  input  wire logic              enable_i,
  input  wire elem_t             elem_i,
  input  wire logic [BITS_W-1:0] bits_i,
  input  wire logic              latch_i,
  input  wire logic [BITS_W-1:0] outs_i,
  output logic                   latch_o,
  output logic      [BITS_W-1:0] outs_o
);

  logic              a;
  logic              b;
  logic              r;
  logic [CHAN_W-1:0] oidx;

  // Operand reads.
  assign a    = read_chan(bits_i, elem_i.chan_a);
  assign b    = read_chan(bits_i, elem_i.chan_b);
  assign oidx = elem_i.out_chan - CHAN_W'(1);

  // Gate or latch evaluation; reset dominates on the latch.
  always_comb begin
    latch_o = latch_i;
    r       = 1'b0;
    unique case (elem_i.op)
      OP_AND: r = a & b;
      OP_OR:  r = a | b;
      OP_NOT: r = ~a;
      OP_RS: begin
        if (enable_i && elem_i.valid) begin
          if (b) begin
            latch_o = 1'b0;
          end else if (a) begin
            latch_o = 1'b1;
          end
        end
        r = latch_o;
      end
      default: r = 1'b0;
    endcase
  end

  // Output write; a later element overrides what came before.
  always_comb begin
    outs_o = outs_i;
    if (enable_i && elem_i.valid && (elem_i.out_chan != '0) &&
        (elem_i.out_chan <= CHAN_W'(OUT_LIMIT))) begin
      outs_o[oidx[$clog2(BITS_W)-1:0]] = r;
    end
  end

endmodule

`default_nettype wire
